// ----- hw/rtl/postfix_expression_evaluator_top_assert.svh -----
// Assertion macros for the postfix evaluator checker.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_TOP_ASSERT_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_TOP_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define PFX_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define PFX_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/pfx_pkg.sv -----
// Shared types, constants and helpers of the postfix evaluator.
package pfx_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int DATA_WIDTH  = 32;
	localparam int VALUE_W     = 32;
	localparam int SYM_W       = 8;
	localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
	localparam int PTR_W       = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(DATA_WIDTH);

	localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [SYM_W-1:0] CH_STAR  = 8'h2A;
	localparam logic [SYM_W-1:0] CH_SLASH = 8'h2F;
	localparam logic [SYM_W-1:0] CH_0     = 8'h30;
	localparam logic [SYM_W-1:0] CH_9     = 8'h39;

	typedef enum logic [1:0] {
		ST_OK,
		ST_SYNTAX,
		ST_DIVZERO,
		ST_OVERFLOW
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_OP_CHECK,
		S_RD_LHS,
		S_CAPL,
		S_DIV,
		S_DIV_FIX,
		S_WB,
		S_END_RD,
		S_END_CAP
	} state_t;

	function automatic logic [DATA_WIDTH-1:0] magnitude(input logic [DATA_WIDTH-1:0] v);
		return v[DATA_WIDTH-1] ? (~v + 1'b1) : v;
	endfunction

endpackage

// ----- hw/rtl/pfx_sym_if.sv -----
// Request channel carrying one expression character.
interface pfx_sym_if;
	logic                        valid;
	logic                        ready;
	logic [pfx_pkg::SYM_W-1:0]   symbol;
	logic                        expression_end;

	modport source (output valid, output symbol, output expression_end, input ready);
	modport sink   (input valid, input symbol, input expression_end, output ready);
endinterface

// ----- hw/rtl/pfx_res_if.sv -----
// Request channel carrying one evaluation result.
interface pfx_res_if;
	logic                               valid;
	logic                               ready;
	logic signed [pfx_pkg::VALUE_W-1:0] value;
	logic [1:0]                         status;

	modport source (output valid, output value, output status, input ready);
	modport sink   (input valid, input value, input status, output ready);
endinterface

// ----- hw/rtl/pfx_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pfx_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hw/rtl/postfix_expression_evaluator_top.sv -----
// Postfix expression evaluator top: characters in, one value and status per expression out.
// Digits and ignored characters are taken in S_IDLE; + - * go through S_OP_CHECK, S_RD_LHS, S_CAPL and S_WB
// (stack RAM reads are registered); / adds S_DIV and S_DIV_FIX of the radix-2 restoring divider.
// End request: S_END_RD, then S_END_CAP, which registers the result once the output is free, then S_IDLE.
// arst_n (async, active low) clears depth, number, error and result valid; stack RAM is not cleared.
module postfix_expression_evaluator_top (
	input  logic       clk,
	input  logic       arst_n,
	pfx_sym_if.sink    expr,
	pfx_res_if.source  result
);

	localparam int DW = pfx_pkg::DATA_WIDTH;

	pfx_pkg::state_t  state_q, state_d;
	pfx_pkg::status_t err_q;

	logic [pfx_pkg::DEPTH_W-1:0] depth_q;
	logic [DW-1:0]               acc_q;
	logic                        in_number_q;
	logic [pfx_pkg::SYM_W-1:0]   op_q;
	logic [DW-1:0]               rhs_q;
	logic [DW-1:0]               res_q;
	logic [DW-1:0]               quo_q;
	logic [DW-1:0]               rem_q;
	logic [DW-1:0]               div_q;
	logic                        neg_q;
	logic [pfx_pkg::CNT_W-1:0]   cnt_q;
	logic                        out_valid_q;
	logic [pfx_pkg::VALUE_W-1:0] out_value_q;
	pfx_pkg::status_t            out_status_q;

	logic                        ram_we;
	logic [pfx_pkg::PTR_W-1:0]   ram_waddr;
	logic [DW-1:0]               ram_wdata;
	logic [pfx_pkg::PTR_W-1:0]   ram_raddr;
	logic [DW-1:0]               ram_rdata;

	logic                        accept;
	logic                        is_digit;
	logic                        is_op;
	logic                        push_req;
	logic                        full;
	logic                        push_ok;
	logic                        push_ovf;
	logic                        out_free;
	logic [pfx_pkg::DEPTH_W-1:0] depth_m1;
	logic [pfx_pkg::DEPTH_W-1:0] depth_m2;
	logic [DW-1:0]               acc_next;
	logic [DW-1:0]               prod;
	logic [DW:0]                 div_sh;
	logic [DW:0]                 div_diff;

	pfx_ram #(
		.WIDTH(DW),
		.DEPTH(pfx_pkg::STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign accept   = expr.valid && expr.ready;
	assign is_digit = expr.symbol inside {[pfx_pkg::CH_0:pfx_pkg::CH_9]};
	assign is_op    = expr.symbol inside {pfx_pkg::CH_PLUS, pfx_pkg::CH_MINUS,
		pfx_pkg::CH_STAR, pfx_pkg::CH_SLASH};
	assign push_req = accept && (err_q == pfx_pkg::ST_OK) && in_number_q &&
		(expr.expression_end || !is_digit);
	assign full     = depth_q == pfx_pkg::DEPTH_W'(pfx_pkg::STACK_DEPTH);
	assign push_ok  = push_req && !full;
	assign push_ovf = push_req && full;
	assign out_free = !out_valid_q || result.ready;
	assign depth_m1 = depth_q - pfx_pkg::DEPTH_W'(1);
	assign depth_m2 = depth_q - pfx_pkg::DEPTH_W'(2);
	assign acc_next = (acc_q << 3) + (acc_q << 1) + DW'(expr.symbol - pfx_pkg::CH_0);
	assign prod     = ram_rdata * rhs_q;
	assign div_sh   = {rem_q, quo_q[DW-1]};
	assign div_diff = div_sh - {1'b0, div_q};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pfx_pkg::S_IDLE: begin
				if (accept) begin
					if (expr.expression_end) begin
						state_d = pfx_pkg::S_END_RD;
					end else if (err_q == pfx_pkg::ST_OK && is_op && !push_ovf) begin
						state_d = pfx_pkg::S_OP_CHECK;
					end
				end
			end
			pfx_pkg::S_OP_CHECK: begin
				state_d = (depth_q < pfx_pkg::DEPTH_W'(2)) ? pfx_pkg::S_IDLE : pfx_pkg::S_RD_LHS;
			end
			pfx_pkg::S_RD_LHS: begin
				if (op_q == pfx_pkg::CH_SLASH && ram_rdata == '0) begin
					state_d = pfx_pkg::S_IDLE;
				end else begin
					state_d = pfx_pkg::S_CAPL;
				end
			end
			pfx_pkg::S_CAPL: begin
				state_d = (op_q == pfx_pkg::CH_SLASH) ? pfx_pkg::S_DIV : pfx_pkg::S_WB;
			end
			pfx_pkg::S_DIV: begin
				if (cnt_q == pfx_pkg::CNT_W'(DW - 1)) begin
					state_d = pfx_pkg::S_DIV_FIX;
				end
			end
			pfx_pkg::S_DIV_FIX: state_d = pfx_pkg::S_WB;
			pfx_pkg::S_WB:      state_d = pfx_pkg::S_IDLE;
			pfx_pkg::S_END_RD:  state_d = pfx_pkg::S_END_CAP;
			pfx_pkg::S_END_CAP: begin
				if (out_free) begin
					state_d = pfx_pkg::S_IDLE;
				end
			end
			default: state_d = pfx_pkg::S_IDLE;
		endcase
	end

	// stack port control and handshake outputs
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = depth_q[pfx_pkg::PTR_W-1:0];
		ram_wdata = acc_q;
		ram_raddr = '0;
		case (state_q)
			pfx_pkg::S_IDLE:     ram_we = push_ok;
			pfx_pkg::S_OP_CHECK: ram_raddr = depth_m1[pfx_pkg::PTR_W-1:0];
			pfx_pkg::S_RD_LHS:   ram_raddr = depth_m2[pfx_pkg::PTR_W-1:0];
			pfx_pkg::S_WB: begin
				ram_we    = 1'b1;
				ram_waddr = depth_m2[pfx_pkg::PTR_W-1:0];
				ram_wdata = res_q;
			end
			default: ram_raddr = '0;
		endcase
	end

	assign expr.ready    = state_q == pfx_pkg::S_IDLE;
	assign result.valid  = out_valid_q;
	assign result.value  = out_value_q;
	assign result.status = out_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pfx_pkg::S_IDLE;
			err_q       <= pfx_pkg::ST_OK;
			depth_q     <= '0;
			acc_q       <= '0;
			in_number_q <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == pfx_pkg::S_END_CAP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				pfx_pkg::S_IDLE: begin
					if (accept && err_q == pfx_pkg::ST_OK) begin
						if (!expr.expression_end && is_digit) begin
							acc_q       <= acc_next;
							in_number_q <= 1'b1;
						end else if (in_number_q) begin
							acc_q       <= '0;
							in_number_q <= 1'b0;
							if (push_ovf) begin
								err_q <= pfx_pkg::ST_OVERFLOW;
							end else begin
								depth_q <= depth_q + pfx_pkg::DEPTH_W'(1);
							end
						end
					end
				end
				pfx_pkg::S_OP_CHECK: begin
					if (depth_q < pfx_pkg::DEPTH_W'(2)) begin
						err_q <= pfx_pkg::ST_SYNTAX;
					end
				end
				pfx_pkg::S_RD_LHS: begin
					if (op_q == pfx_pkg::CH_SLASH && ram_rdata == '0) begin
						err_q <= pfx_pkg::ST_DIVZERO;
					end
				end
				pfx_pkg::S_CAPL: cnt_q <= '0;
				pfx_pkg::S_DIV:  cnt_q <= cnt_q + pfx_pkg::CNT_W'(1);
				pfx_pkg::S_WB:   depth_q <= depth_m1;
				pfx_pkg::S_END_RD: begin
					if (err_q == pfx_pkg::ST_OK && depth_q != pfx_pkg::DEPTH_W'(1)) begin
						err_q <= pfx_pkg::ST_SYNTAX;
					end
				end
				pfx_pkg::S_END_CAP: begin
					if (out_free) begin
						err_q       <= pfx_pkg::ST_OK;
						depth_q     <= '0;
						acc_q       <= '0;
						in_number_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// operand, divider and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			pfx_pkg::S_IDLE: op_q <= expr.symbol;
			pfx_pkg::S_RD_LHS: rhs_q <= ram_rdata;
			pfx_pkg::S_CAPL: begin
				case (op_q)
					pfx_pkg::CH_PLUS:  res_q <= ram_rdata + rhs_q;
					pfx_pkg::CH_MINUS: res_q <= ram_rdata - rhs_q;
					pfx_pkg::CH_STAR:  res_q <= prod;
					default: begin
						neg_q <= ram_rdata[DW-1] ^ rhs_q[DW-1];
						quo_q <= pfx_pkg::magnitude(ram_rdata);
						div_q <= pfx_pkg::magnitude(rhs_q);
						rem_q <= '0;
					end
				endcase
			end
			pfx_pkg::S_DIV: begin
				if (!div_diff[DW]) begin
					rem_q <= div_diff[DW-1:0];
					quo_q <= {quo_q[DW-2:0], 1'b1};
				end else begin
					rem_q <= div_sh[DW-1:0];
					quo_q <= {quo_q[DW-2:0], 1'b0};
				end
			end
			pfx_pkg::S_DIV_FIX: res_q <= neg_q ? (~quo_q + 1'b1) : quo_q;
			pfx_pkg::S_END_CAP: begin
				if (out_free) begin
					out_value_q  <= (err_q == pfx_pkg::ST_OK) ? ram_rdata[pfx_pkg::VALUE_W-1:0] : '0;
					out_status_q <= err_q;
				end
			end
			default: ;
		endcase
	end

endmodule

// ----- hw/rtl/pfx_chk.sv -----
// Port-level checker for the postfix evaluator, bound to the top level.
`include "postfix_expression_evaluator_top_assert.svh"

module pfx_chk (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               expr_valid,
	input logic                               expr_ready,
	input logic                               expr_end,
	input logic                               res_valid,
	input logic                               res_ready,
	input logic signed [pfx_pkg::VALUE_W-1:0] res_value,
	input logic [1:0]                         res_status
);

	`PFX_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_value) && $stable(res_status), "result dropped or changed while stalled")
	`PFX_ASSERT_NOW(a_err_zero, res_valid && res_status != pfx_pkg::ST_OK, res_value == '0, "nonzero value with error status")
	`PFX_ASSERT_NEXT(a_end_busy, expr_valid && expr_ready && expr_end, !expr_ready, "end request did not stall input")
	`PFX_ASSERT_NOW(a_res_busy, $rose(res_valid), $past(!expr_ready), "result raised while input was idle")

endmodule

bind postfix_expression_evaluator_top pfx_chk u_pfx_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.expr_valid (expr.valid),
	.expr_ready (expr.ready),
	.expr_end   (expr.expression_end),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.res_value  (result.value),
	.res_status (result.status)
);

// ----- dv/tb_postfix_expression_evaluator_top.sv -----
// Testbench for the postfix evaluator: random character streams checked by a predictor.
module tb_postfix_expression_evaluator_top;
	import pfx_pkg::*;

	localparam int unsigned ITEM_TARGET  = 950;
	localparam int unsigned CYCLE_LIMIT  = 400_000;
	localparam int unsigned DRAIN_CYCLES = 40;
	localparam int unsigned HOLD_AFTER   = 12;
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned RADIX        = 10;
	localparam logic [SYM_W-1:0] CH_SPACE = 8'h20;

	typedef enum int unsigned {
		FLAW_NONE,
		FLAW_EARLY_OP,
		FLAW_NO_OP,
		FLAW_CUT
	} flaw_t;

	class postfix_tracker;
		typedef struct {
			logic signed [VALUE_W-1:0] value;
			status_t                   status;
		} outcome_t;

		logic [DATA_WIDTH-1:0] operands [STACK_DEPTH];
		int unsigned           depth;
		logic [DATA_WIDTH-1:0] accum;
		bit                    building;
		status_t               fault;
		outcome_t              due_q [$];
		int unsigned           mismatches;

		function new();
			mismatches = 0;
			clear();
		endfunction

		function void clear();
			depth    = 0;
			accum    = '0;
			building = 1'b0;
			fault    = ST_OK;
		endfunction

		function int unsigned outstanding();
			return due_q.size();
		endfunction

		function void push_operand(logic [DATA_WIDTH-1:0] v);
			if (depth >= STACK_DEPTH) begin
				fault = ST_OVERFLOW;
				return;
			end
			operands[depth] = v;
			depth++;
		endfunction

		function void apply_op(logic [SYM_W-1:0] op);
			logic [DATA_WIDTH-1:0] lhs, rhs, res, lmag, rmag, quo;
			if (depth < 2) begin
				fault = ST_SYNTAX;
				return;
			end
			rhs = operands[depth-1];
			lhs = operands[depth-2];
			case (op)
				CH_PLUS:  res = lhs + rhs;
				CH_MINUS: res = lhs - rhs;
				CH_STAR:  res = lhs * rhs;
				default: begin
					if (rhs == '0) begin
						fault = ST_DIVZERO;
						return;
					end
					lmag = lhs[DATA_WIDTH-1] ? -lhs : lhs;
					rmag = rhs[DATA_WIDTH-1] ? -rhs : rhs;
					quo  = lmag / rmag;
					res  = (lhs[DATA_WIDTH-1] != rhs[DATA_WIDTH-1]) ? -quo : quo;
				end
			endcase
			depth -= 2;
			push_operand(res);
		endfunction

		// Accepted request: advance the mirror state, queue an outcome on end.
		function void take_char(logic [SYM_W-1:0] sym, logic fin);
			outcome_t o;
			if (!fin) begin
				if (fault != ST_OK)
					return;
				if (sym >= CH_0 && sym <= CH_9) begin
					accum    = accum * RADIX + (sym - CH_0);
					building = 1'b1;
					return;
				end
				if (building) begin
					push_operand(accum);
					accum    = '0;
					building = 1'b0;
					if (fault != ST_OK)
						return;
				end
				if (sym == CH_PLUS || sym == CH_MINUS || sym == CH_STAR || sym == CH_SLASH)
					apply_op(sym);
				return;
			end
			if (fault == ST_OK && building)
				push_operand(accum);
			if (fault == ST_OK && depth != 1)
				fault = ST_SYNTAX;
			o.status = fault;
			o.value  = (fault == ST_OK) ? operands[0][VALUE_W-1:0] : '0;
			due_q.push_back(o);
			clear();
		endfunction

		function void check_result(logic signed [VALUE_W-1:0] value, logic [1:0] status);
			outcome_t o;
			if (due_q.size() == 0) begin
				if (mismatches < 10)
					$display("ERROR: unexpected result value=%0d status=%0d", value, status);
				mismatches++;
				return;
			end
			o = due_q.pop_front();
			if (value !== o.value || status !== o.status) begin
				if (mismatches < 10)
					$display("ERROR: expected value=%0d status=%0d, got value=%0d status=%0d",
						o.value, o.status, value, status);
				mismatches++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	int unsigned cycle_count = 0;
	int unsigned counted_items = 0;
	bit          sender_idle_on = 1'b1;

	postfix_tracker tracker;

	pfx_sym_if expr_ch ();
	pfx_res_if res_ch ();

	postfix_expression_evaluator_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.expr   (expr_ch),
		.result (res_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("postfix_expression_evaluator_top test failed");
			$finish;
		end
	end

	function automatic bit is_digit(logic [SYM_W-1:0] c);
		return c >= CH_0 && c <= CH_9;
	endfunction

	function automatic bit is_op(logic [SYM_W-1:0] c);
		return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH;
	endfunction

	function automatic logic [SYM_W-1:0] pick_filler();
		logic [SYM_W-1:0] c;
		if ($urandom_range(0, 1) == 0)
			return CH_SPACE;
		do c = SYM_W'($urandom_range(0, 255)); while (is_digit(c) || is_op(c));
		return c;
	endfunction

	function automatic logic [SYM_W-1:0] pick_op(bit with_div);
		case ($urandom_range(0, with_div ? 3 : 2))
			0:       return CH_PLUS;
			1:       return CH_MINUS;
			2:       return CH_STAR;
			default: return CH_SLASH;
		endcase
	endfunction

	function automatic int unsigned number_len();
		return ($urandom_range(0, 7) == 0) ? $urandom_range(3, 11) : $urandom_range(1, 2);
	endfunction

	task automatic send_item(input logic [SYM_W-1:0] sym, input logic fin);
		int unsigned gap;
		gap = sender_idle_on ? $urandom_range(0, 6) : 0;
		if (gap != 0) begin
			expr_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		expr_ch.valid          <= 1'b1;
		expr_ch.symbol         <= sym;
		expr_ch.expression_end <= fin;
		do @(posedge clk); while (!expr_ch.ready);
		tracker.take_char(sym, fin);
		counted_items++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], 1'b0);
	endtask

	task automatic send_number(input int unsigned ndig);
		repeat (ndig) send_item(SYM_W'(CH_0 + $urandom_range(0, 9)), 1'b0);
	endtask

	task automatic send_expression(input int unsigned nnum, input flaw_t flaw);
		int unsigned left;
		int unsigned live;
		bit          after_num;
		left      = nnum;
		live      = 0;
		after_num = 1'b0;
		if (flaw == FLAW_EARLY_OP)
			send_item(pick_op(1'b1), 1'b0);
		while (left != 0 || live > 1) begin
			if (flaw == FLAW_CUT && $urandom_range(0, 5) == 0)
				break;
			if (left != 0 && (live < 2 || $urandom_range(0, 2) != 0)) begin
				if (after_num)
					send_item(pick_filler(), 1'b0);
				send_number(number_len());
				if ($urandom_range(0, 4) == 0)
					send_item(pick_filler(), 1'b0);
				after_num = 1'b1;
				live++;
				left--;
			end else begin
				if (flaw == FLAW_NO_OP && left == 0)
					break;
				send_item(pick_op(1'b1), 1'b0);
				live--;
				after_num = 1'b0;
			end
		end
		send_item(SYM_W'($urandom_range(0, 255)), 1'b1);
	endtask

	// Fill the stack with nnum single digits, optionally fold it back down.
	task automatic send_deep(input int unsigned nnum, input bit fold, input bit end_on_number);
		for (int i = 0; i < nnum; i++) begin
			send_number(1);
			if (i != nnum - 1 || !end_on_number)
				send_item(pick_filler(), 1'b0);
		end
		if (fold)
			repeat (nnum - 1) send_item(pick_op(1'b0), 1'b0);
		send_item(SYM_W'($urandom_range(0, 255)), 1'b1);
	endtask

	initial begin : drain
		int unsigned stall;
		int unsigned taken;
		bit          quiet;
		taken        = 0;
		quiet        = 1'b0;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 7) == 0)
				quiet = !quiet;
			stall = quiet ? 0 : $urandom_range(0, 6);
			if (taken == HOLD_AFTER)
				stall = HOLD_CYCLES;
			if (stall != 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
			tracker.check_result(res_ch.value, res_ch.status);
			taken++;
		end
	end

	initial begin : stimulus
		int unsigned pick;
		tracker                = new();
		arst_n                 = 1'b0;
		expr_ch.valid          = 1'b0;
		expr_ch.symbol         = '0;
		expr_ch.expression_end = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all four operators, then too few operands, divide by zero,
		// ignored extremes with a number still open at end, empty expression
		send_text("9 4-3*2/1+");
		send_item("7", 1'b1);
		send_text("+");
		send_item(8'hFF, 1'b1);
		send_text("1 0/");
		send_item(8'h00, 1'b1);
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item("5", 1'b0);
		send_item(8'h5A, 1'b1);
		send_item(8'h00, 1'b1);

		// full stack, overflow, most negative over minus one
		send_deep(STACK_DEPTH, 1'b1, 1'b0);
		send_deep(STACK_DEPTH + 1, 1'b0, $urandom_range(0, 1));
		send_text("2147483648 0 1-/");
		send_item(CH_SPACE, 1'b1);
		send_text("2147483648 4294967295/");
		send_item(CH_SPACE, 1'b1);

		while (counted_items < ITEM_TARGET) begin
			if ($urandom_range(0, 3) == 0)
				sender_idle_on = !sender_idle_on;
			pick = $urandom_range(0, 15);
			if (pick <= 10) begin
				send_expression($urandom_range(1, 8), FLAW_NONE);
			end else if (pick == 11) begin
				send_expression($urandom_range(1, 6), FLAW_EARLY_OP);
			end else if (pick == 12) begin
				send_expression($urandom_range(2, 6), FLAW_NO_OP);
			end else if (pick == 13) begin
				send_expression($urandom_range(1, 6), FLAW_CUT);
			end else if (pick == 14) begin
				repeat ($urandom_range(3, 12))
					send_item(SYM_W'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
				send_item(SYM_W'($urandom_range(0, 255)), 1'b1);
			end else begin
				case ($urandom_range(0, 2))
					0:       send_text("2147483648 0 1-/");
					1:       send_text("2147483648 4294967295/");
					default: begin
						send_number(number_len());
						send_text(" 0/");
					end
				endcase
				send_item(SYM_W'($urandom_range(0, 255)), 1'b1);
			end
		end
		expr_ch.valid <= 1'b0;

		while (tracker.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
			$display("postfix_expression_evaluator_top test passed");
		end else begin
			$display("postfix_expression_evaluator_top test failed");
		end
		$finish;
	end

endmodule
